@@ sv/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, widths and codes for the percentile contrast stretch block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    // field and storage widths
    localparam int PIX_W      = 8;
    localparam int PCT_W      = 7;
    localparam int CNT_W      = 21;
    localparam int BINS       = 256;
    localparam int BIN_IDX_W  = 8;
    localparam int TGT_W      = 28;   // percent * total
    localparam int CNT100_W   = 28;   // 100 * one bin count
    localparam int ACC_W      = 36;   // 100 * running sum over all bins
    localparam int LIM_CMP_W  = 25;   // wide enough for the pixel limit

    // default pixel count limit per frame
    localparam int MAX_PIXELS = 1048576;

    // numerator of the gain division
    localparam logic [PIX_W-1:0] DIV_NUM = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // operation codes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PCT_W;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT = 1'd1;
    localparam logic [PCT_W-1:0] LOW_PCT_RST  = 7'd5;
    localparam logic [PCT_W-1:0] HIGH_PCT_RST = 7'd95;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] mapped_pixel;
        logic [PIX_W-1:0] lower_limit;
        logic [PIX_W-1:0] upper_limit;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic new_frame;
        logic cnt_rd;
        logic cnt_wr;
        logic sweep_init;
        logic sweep_run;
        logic div_start;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic total_ok;
        logic sweep_done;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/pcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer for counting, limit sweep, gain division and mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_op,
    output logic                     o_in_stall,
    input  wire pcs_pkg::t_dp_status i_status,
    output pcs_pkg::t_dp_cmd         o_cmd
);
    import pcs_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CNT_RD   = 3'd1;
    localparam logic [2:0] S_CNT_WR   = 3'd2;
    localparam logic [2:0] S_SWP_INIT = 3'd3;
    localparam logic [2:0] S_SWP      = 3'd4;
    localparam logic [2:0] S_DIV_INIT = 3'd5;
    localparam logic [2:0] S_DIV      = 3'd6;
    localparam logic [2:0] S_MAP      = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_phase, n_phase;
    logic       in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load_in = 1'b1;
                    if (i_in_op == OP_COUNT) begin
                        o_cmd.new_frame = r_phase;
                        n_phase         = 1'b0;
                        n_state         = S_CNT_RD;
                    end else if (r_phase) begin
                        n_state = S_MAP;
                    end else begin
                        n_state = S_SWP_INIT;
                    end
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = i_status.total_ok;
                n_state      = i_status.total_ok ? S_CNT_WR : S_IDLE;
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_SWP_INIT: begin
                o_cmd.sweep_init = 1'b1;
                n_state          = S_SWP;
            end
            S_SWP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_phase = 1'b1;
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

@@ sv/pcs_datapath.sv @@
// ----------------------------------------------------------------------------
// pcs_datapath
// Histogram memory, percentile sweep pipeline, gain divider, pixel mapper
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_datapath #(
    parameter int MAX_PIXELS = pcs_pkg::MAX_PIXELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pcs_pkg::t_in_item               i_in_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire pcs_pkg::t_dp_cmd                i_cmd,
    output pcs_pkg::t_dp_status                  o_status,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pcs_pkg::t_out_item                   o_out_item
);
    import pcs_pkg::*;

    // pixel count limit at compare width
    localparam logic [LIM_CMP_W-1:0] MAX_PIX_LIM = LIM_CMP_W'(MAX_PIXELS);

    // configuration
    logic [PCT_W-1:0] r_low_pct, r_high_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pct  <= LOW_PCT_RST;
            r_high_pct <= HIGH_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_PCT:  r_low_pct  <= i_cfg_data;
                REG_HIGH_PCT: r_high_pct <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input pixel latch
    logic [PIX_W-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pix <= i_in_item.pixel;
        end
    end

    // histogram memory with per-bin valid bits
    logic [CNT_W-1:0]     r_mem [BINS];
    logic [BINS-1:0]      r_vbits;
    logic [CNT_W-1:0]     r_rd_data;
    logic                 r_rd_vbit;
    logic [CNT_W-1:0]     rd_count;
    logic                 rd_en;
    logic [BIN_IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0]     r_total;

    // sweep address counter, one past the last bin means all issued
    logic [BIN_IDX_W:0]   r_swp_addr;
    logic                 swp_issue;

    assign swp_issue = i_cmd.sweep_run && !r_swp_addr[BIN_IDX_W];
    assign rd_en     = i_cmd.cnt_rd || swp_issue;
    assign rd_addr   = i_cmd.cnt_rd ? r_pix : r_swp_addr[BIN_IDX_W-1:0];
    assign rd_count  = r_rd_vbit ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vbit <= r_vbits[rd_addr];
        end
        if (i_cmd.cnt_wr) begin
            r_mem[r_pix] <= rd_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
            r_total <= '0;
        end else if (i_cmd.new_frame) begin
            r_vbits <= '0;
            r_total <= '0;
        end else if (i_cmd.cnt_wr) begin
            r_vbits[r_pix] <= 1'b1;
            r_total        <= r_total + CNT_W'(1);
        end
    end

    // sweep pipeline: read, scale by 100, accumulate and compare
    logic                 r_s1_v, r_s2_v;
    logic [BIN_IDX_W-1:0] r_s1_idx, r_s2_idx;
    logic [CNT100_W-1:0]  r_cnt100;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     acc_next;
    logic [ACC_W-1:0]     lo_tgt_w, hi_tgt_w;
    logic [TGT_W-1:0]     r_lo_tgt, r_hi_tgt;
    logic [PIX_W-1:0]     r_low_bin, r_high_bin;

    assign acc_next = r_acc + ACC_W'(r_cnt100);
    assign lo_tgt_w = ACC_W'(r_lo_tgt);
    assign hi_tgt_w = ACC_W'(r_hi_tgt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
        end else if (i_cmd.sweep_init) begin
            r_swp_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            if (swp_issue) begin
                r_swp_addr <= r_swp_addr + (BIN_IDX_W+1)'(1);
            end
            r_s1_v <= swp_issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_swp_addr[BIN_IDX_W-1:0];
        r_s2_idx <= r_s1_idx;
        r_cnt100 <= CNT100_W'(rd_count) * CNT100_W'(100);
        if (i_cmd.sweep_init) begin
            r_lo_tgt <= TGT_W'(r_low_pct) * TGT_W'(r_total);
            r_hi_tgt <= TGT_W'(r_high_pct) * TGT_W'(r_total);
        end
    end

    // running sum and limit capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_low_bin  <= '0;
            r_high_bin <= '0;
        end else if (i_cmd.sweep_init) begin
            r_acc      <= '0;
            r_low_bin  <= '0;
            r_high_bin <= '0;
        end else if (r_s2_v) begin
            r_acc <= acc_next;
            if (r_acc < lo_tgt_w && acc_next >= lo_tgt_w) begin
                r_low_bin <= r_s2_idx;
            end
            if (r_acc < hi_tgt_w && acc_next >= hi_tgt_w) begin
                r_high_bin <= r_s2_idx;
            end
        end
    end

    // restoring divider for 255 / span, one quotient bit per cycle
    logic [PIX_W-1:0] r_gain, r_rem, r_den;
    logic [2:0]       r_div_cnt;
    logic             r_div_busy;
    logic [PIX_W:0]   div_tmp;
    logic             div_ge;

    assign div_tmp = {r_rem, DIV_NUM[r_div_cnt]};
    assign div_ge  = div_tmp >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_gain     <= '0;
        end else if (i_cmd.div_start) begin
            r_gain    <= '0;
            r_div_cnt <= 3'd7;
            r_div_busy <= (r_high_bin > r_low_bin);
        end else if (r_div_busy) begin
            r_gain <= {r_gain[PIX_W-2:0], div_ge};
            if (r_div_cnt == 3'd0) begin
                r_div_busy <= 1'b0;
            end else begin
                r_div_cnt <= r_div_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_den <= r_high_bin - r_low_bin;
        end else if (r_div_busy) begin
            r_rem <= div_ge ? PIX_W'(div_tmp - {1'b0, r_den}) : div_tmp[PIX_W-1:0];
        end
    end

    // pixel mapping
    logic [PIX_W-1:0]   map_diff;
    logic [2*PIX_W-1:0] map_prod;
    logic [PIX_W-1:0]   map_pix;

    always_comb begin
        map_diff = r_pix - r_low_bin;
        map_prod = r_gain * map_diff;
        if (r_pix < r_low_bin) begin
            map_pix = '0;
        end else if (r_pix > r_high_bin) begin
            map_pix = PIX_MAX;
        end else begin
            map_pix = map_prod[PIX_W-1:0];
        end
    end

    // output register
    logic      r_out_valid;
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.mapped_pixel <= map_pix;
            r_out_item.lower_limit  <= r_low_bin;
            r_out_item.upper_limit  <= r_high_bin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // status to the controller
    assign o_status.total_ok   = {{(LIM_CMP_W-CNT_W){1'b0}}, r_total} < MAX_PIX_LIM;
    assign o_status.sweep_done = r_swp_addr[BIN_IDX_W] && !r_s1_v && !r_s2_v;
    assign o_status.div_busy   = r_div_busy;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

@@ sv/percentile_contrast_stretch_top.sv @@
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_top
// Two-pass 8-bit contrast stretch with percentile clip limits.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------
//   in       | input     | i_in_valid / o_in_stall   | i_in_item (op, pixel)
//   out      | output    | o_out_valid / i_out_stall | o_out_item (mapped,
//            |           |                           |   lower, upper limit)
//   cfg      | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A count transaction steps through accept, bin read and bin write; at the
// pixel limit the read and write are skipped. A map transaction in the
// mapping phase steps through accept and map. The first map after counting
// first runs the limit sweep, which reads one histogram bin per cycle from
// the bin memory, then the gain divider, one quotient bit per cycle.
// Reset clears the bin valid bits at once; no clearing pass is needed.
// A stalled output holds only the map step; the next transaction is still
// accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module percentile_contrast_stretch_top #(
    parameter int MAX_PIXELS = pcs_pkg::MAX_PIXELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire pcs_pkg::t_in_item               i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pcs_pkg::t_out_item                   o_out_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pcs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // control sequencer
    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_item.op),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // histogram, sweep, divider and mapper
    pcs_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ sv/pcs_checker.sv @@
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks for the contrast stretch block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_stall,
    input  wire pcs_pkg::t_in_item               i_in_item,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    input  wire pcs_pkg::t_out_item              o_out_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pcs_pkg::*;

    logic in_acc;
    logic cfg_seen;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_seen = i_cfg_we && (i_cfg_idx == REG_LOW_PCT || i_cfg_idx == REG_HIGH_PCT)
                      && (i_cfg_data == i_cfg_data);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // one transaction at a time: input is stalled right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second transaction accepted while busy");

    // a count transaction never produces a result
    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.op == OP_COUNT && !cfg_seen |=> !$rose(o_out_valid))
        else $error("result after count transaction");

    // with no span between the limits only black or white can come out
    a_no_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.lower_limit >= o_out_item.upper_limit |->
        o_out_item.mapped_pixel == '0 || o_out_item.mapped_pixel == PIX_MAX)
        else $error("mapped value inside an empty span");

endmodule

bind percentile_contrast_stretch_top pcs_checker u_pcs_checker (.*);

`default_nettype wire

@@ sim/percentile_contrast_stretch_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_top_tb
// Sends count and map transactions with random gaps on both channels and
// checks every stretched pixel and both clip limits against an in-bench
// histogram model. A directed opening covers the corner cases; the rest is
// random frames of clustered or uniform pixels under changing percentiles.
// ----------------------------------------------------------------------------

module percentile_contrast_stretch_top_tb;
    import pcs_pkg::*;

    localparam int SETTLE_CYCLES = 300;      // longest limit sweep plus divider
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1200;

    // histogram model and queue of stretched pixels still to arrive
    class stretch_checker;
        logic [CNT_W-1:0] hist [BINS];
        logic [CNT_W-1:0] total;
        logic [PIX_W-1:0] lower;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] gain;
        logic             mapping;
        logic [PCT_W-1:0] low_pct;
        logic [PCT_W-1:0] high_pct;
        t_out_item        pending_maps [$];
        int               errors;

        function new();
            foreach (hist[i]) hist[i] = '0;
            total    = '0;
            lower    = '0;
            upper    = '0;
            gain     = '0;
            mapping  = 1'b0;
            low_pct  = LOW_PCT_RST;
            high_pct = HIGH_PCT_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] val);
            if (idx == REG_LOW_PCT)
                low_pct = val;
            else if (idx == REG_HIGH_PCT)
                high_pct = val;
        endfunction

        // update the histogram, or work out the stretched pixel of a map
        function void take_pixel(t_in_item it);
            longint unsigned lo_tgt;
            longint unsigned hi_tgt;
            longint unsigned run;
            longint unsigned prev;
            t_out_item       res;
            if (it.op == OP_COUNT) begin
                // a new frame starts at the first count after mapping
                if (mapping) begin
                    foreach (hist[i]) hist[i] = '0;
                    total   = '0;
                    mapping = 1'b0;
                end
                if (total < MAX_PIXELS) begin
                    hist[it.pixel] = hist[it.pixel] + 1'b1;
                    total          = total + 1'b1;
                end
                return;
            end
            // limit sweep once per frame
            if (!mapping) begin
                lo_tgt = 64'(low_pct) * 64'(total);
                hi_tgt = 64'(high_pct) * 64'(total);
                run    = 0;
                lower  = '0;
                upper  = '0;
                for (int i = 0; i < BINS; i++) begin
                    prev = 100 * run;
                    run  = run + hist[i];
                    if (prev < lo_tgt && 100 * run >= lo_tgt)
                        lower = 8'(i);
                    if (prev < hi_tgt && 100 * run >= hi_tgt)
                        upper = 8'(i);
                end
                if (upper > lower)
                    gain = 8'(255 / (int'(upper) - int'(lower)));
                else
                    gain = '0;
                mapping = 1'b1;
            end
            if (it.pixel < lower)
                res.mapped_pixel = '0;
            else if (it.pixel > upper)
                res.mapped_pixel = PIX_MAX;
            else
                res.mapped_pixel = 8'(int'(gain) * (int'(it.pixel) - int'(lower)));
            res.lower_limit = lower;
            res.upper_limit = upper;
            pending_maps.push_back(res);
        endfunction

        function void check_field(string label, logic [PIX_W-1:0] want,
                                  logic [PIX_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, label, want, got);
            end
        endfunction

        function void check_mapped(t_out_item got);
            t_out_item want;
            if (pending_maps.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: expected nothing, actual %0d %0d %0d",
                         $time, got.mapped_pixel, got.lower_limit, got.upper_limit);
                return;
            end
            want = pending_maps.pop_front();
            check_field("mapped_pixel", want.mapped_pixel, got.mapped_pixel);
            check_field("lower_limit", want.lower_limit, got.lower_limit);
            check_field("upper_limit", want.upper_limit, got.upper_limit);
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_in_item               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    stretch_checker sb;
    bit             quiet    = 1'b0;
    int             sent     = 0;
    int             cycles   = 0;
    int             out_hold = 0;

    percentile_contrast_stretch_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // percent values weighted toward the extremes
    function automatic logic [PCT_W-1:0] pick_pct();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 7'd100;
        if (r == 2)
            return 7'($urandom_range(101, 127));
        return 7'($urandom_range(0, 100));
    endfunction

    // output stall pattern
    always @(negedge clk) begin
        if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
            out_hold  <= $urandom_range(0, 6);
        end else if (!quiet) begin
            out_stall <= 1'b1;
            out_hold  <= idle_len();
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_mapped(out_item);
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("percentile_contrast_stretch_top_tb: errors");
            $finish;
        end
    end

    // one input transaction, entered and left at a falling edge
    task automatic send_item(input logic op_code, input logic [PIX_W-1:0] pix);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        in_item.op    = op_code;
        in_item.pixel = pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_pixel(in_item);
        sent++;
        @(negedge clk);
    endtask

    // drain all results and let a pending sweep finish
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending_maps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PCT_W-1:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial begin
        int base;
        int n_count;
        int n_map;
        int center;
        int spread;
        int v;
        int kind;
        bit clustered;

        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // map on an empty histogram: both limits stay at zero
        send_item(OP_MAP, 8'd0);
        send_item(OP_MAP, 8'd255);

        // percent 0 never reached, percent 100 lands on the top occupied bin
        settle();
        write_reg(REG_LOW_PCT, 7'd0);
        write_reg(REG_HIGH_PCT, 7'd100);
        send_item(OP_COUNT, 8'd10);
        send_item(OP_COUNT, 8'd255);
        send_item(OP_COUNT, 8'd128);
        send_item(OP_MAP, 8'd9);
        send_item(OP_MAP, 8'd10);
        send_item(OP_MAP, 8'd255);
        send_item(OP_MAP, 8'd128);

        // zero span: every pixel in one bin, new frame clears the old one
        settle();
        write_reg(REG_LOW_PCT, 7'd50);
        write_reg(REG_HIGH_PCT, 7'd50);
        repeat (3) send_item(OP_COUNT, 8'd77);
        send_item(OP_MAP, 8'd77);
        send_item(OP_MAP, 8'd76);
        send_item(OP_MAP, 8'd78);

        // inverted span: lower limit above upper limit
        settle();
        write_reg(REG_LOW_PCT, 7'd90);
        write_reg(REG_HIGH_PCT, 7'd10);
        send_item(OP_COUNT, 8'd20);
        send_item(OP_COUNT, 8'd200);
        send_item(OP_MAP, 8'd20);
        send_item(OP_MAP, 8'd210);
        send_item(OP_MAP, 8'd100);

        // percent above 100 is never reached
        settle();
        write_reg(REG_LOW_PCT, 7'd127);
        write_reg(REG_HIGH_PCT, 7'd101);
        send_item(OP_COUNT, 8'd5);
        send_item(OP_MAP, 8'd5);
        send_item(OP_MAP, 8'd0);

        // random frames
        base = sent;
        while (sent - base < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) begin
                settle();
                write_reg(REG_LOW_PCT, pick_pct());
                write_reg(REG_HIGH_PCT, pick_pct());
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: ops mixed at random
                repeat ($urandom_range(1, 20))
                    send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
                if (kind == 1)
                    n_count = 0;
                else if ($urandom_range(0, 9) == 0)
                    n_count = $urandom_range(40, 200);
                else
                    n_count = $urandom_range(1, 30);
                clustered = ($urandom_range(0, 2) != 0);
                center    = $urandom_range(0, 255);
                spread    = $urandom_range(0, 40);
                repeat (n_count) begin
                    if (clustered) begin
                        v = center + int'($urandom_range(0, 2 * spread)) - spread;
                        if (v < 0)
                            v = 0;
                        if (v > 255)
                            v = 255;
                    end else begin
                        v = $urandom_range(0, 255);
                    end
                    send_item(OP_COUNT, 8'(v));
                end
                n_map = $urandom_range(1, 24);
                repeat (n_map) begin
                    if ($urandom_range(0, 1) == 0) begin
                        v = center + int'($urandom_range(0, 2 * spread + 8)) - spread - 4;
                        if (v < 0)
                            v = 0;
                        if (v > 255)
                            v = 255;
                    end else begin
                        v = $urandom_range(0, 255);
                    end
                    send_item(OP_MAP, 8'(v));
                end
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending_maps.size() == 0)
            $display("percentile_contrast_stretch_top_tb: clean");
        else
            $display("percentile_contrast_stretch_top_tb: errors");
        $finish;
    end

endmodule
